>>> sv/tbs_pkg.sv
// Shared constants, action codes, command/status structs and bit helpers
// for the tracked bitmap set. No dependencies.
`timescale 1ns / 1ps

package tbs_pkg;

    localparam int NBITS     = 1024;
    localparam int WORD_BITS = 32;
    localparam int NWORDS    = NBITS / WORD_BITS;
    localparam int IDX_W     = 10;
    localparam int CNT_W     = 11;
    localparam int WADDR_W   = $clog2(NWORDS);
    localparam int WBIT_W    = $clog2(WORD_BITS);

    typedef enum logic [3:0] {
        ACT_TEST      = 4'd0,
        ACT_SET       = 4'd1,
        ACT_CLEAR     = 4'd2,
        ACT_SET_RNG   = 4'd3,
        ACT_CLR_RNG   = 4'd4,
        ACT_KEEP_RNG  = 4'd5,
        ACT_SET_ALL   = 4'd6,
        ACT_CLR_ALL   = 4'd7,
        ACT_INVERT    = 4'd8,
        ACT_NEXT      = 4'd9,
        ACT_PREV      = 4'd10
    } t_action;

    typedef struct packed {
        logic               start;
        logic               cfg_we;
        logic               rd_en;
        logic [WADDR_W-1:0] rd_addr;
        logic               proc_en;
        logic [WADDR_W-1:0] proc_addr;
        logic               finish;
    } t_cmd;

    typedef struct packed {
        logic res_free;
    } t_sts;

    typedef struct packed {
        logic             bit_value;
        logic [IDX_W-1:0] found_index;
        logic             found_valid;
        logic [CNT_W-1:0] set_count;
        logic [IDX_W-1:0] lowest_set;
        logic [IDX_W-1:0] highest_set;
        logic             any_set;
        logic             all_set;
    } t_result;

    function automatic logic [WBIT_W-1:0] lowest_bit(input logic [WORD_BITS-1:0] w);
        logic [WBIT_W-1:0] r;
        r = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (w[j]) r = WBIT_W'(j);
        end
        return r;
    endfunction

    function automatic logic [WBIT_W-1:0] highest_bit(input logic [WORD_BITS-1:0] w);
        logic [WBIT_W-1:0] r;
        r = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            if (w[j]) r = WBIT_W'(j);
        end
        return r;
    endfunction

    function automatic logic [WBIT_W:0] pop_word(input logic [WORD_BITS-1:0] w);
        logic [WBIT_W:0] r;
        r = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            r = r + (WBIT_W + 1)'(w[j]);
        end
        return r;
    endfunction

endpackage

>>> sv/tbs_ifs.sv
// Valid/ready channel interfaces for requests, results and configuration.
// Depends on tbs_pkg.
`timescale 1ns / 1ps

interface tbs_req_if;
    logic                      valid;
    logic                      ready;
    logic [3:0]                action;
    logic [tbs_pkg::IDX_W-1:0] index;
    logic [tbs_pkg::IDX_W-1:0] range_end;
    modport source (output valid, action, index, range_end, input ready);
    modport sink   (input valid, action, index, range_end, output ready);
endinterface

interface tbs_res_if;
    logic                      valid;
    logic                      ready;
    logic                      bit_value;
    logic [tbs_pkg::IDX_W-1:0] found_index;
    logic                      found_valid;
    logic [tbs_pkg::CNT_W-1:0] set_count;
    logic [tbs_pkg::IDX_W-1:0] lowest_set;
    logic [tbs_pkg::IDX_W-1:0] highest_set;
    logic                      any_set;
    logic                      all_set;
    modport source (output valid, bit_value, found_index, found_valid, set_count,
                    lowest_set, highest_set, any_set, all_set, input ready);
    modport sink   (input valid, bit_value, found_index, found_valid, set_count,
                    lowest_set, highest_set, any_set, all_set, output ready);
endinterface

interface tbs_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [tbs_pkg::CNT_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> sv/tbs_ctrl.sv
// Sequencer for the tracked bitmap set: walks the word store once per request.
// Depends on tbs_pkg.
`timescale 1ns / 1ps

module tbs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  logic          i_cfg_valid,
    input  tbs_pkg::t_sts i_sts,
    output logic          o_idle,
    output tbs_pkg::t_cmd o_cmd
);
    import tbs_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    t_state             r_state;
    logic [WADDR_W:0]   r_cnt;

    // hold state and the word counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    r_cnt <= '0;
                    if (i_req_valid) r_state <= ST_SCAN;
                end
                ST_SCAN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == (WADDR_W + 1)'(NWORDS)) r_state <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (i_sts.res_free) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // issue read of one word while the previous word is processed
    assign o_idle          = (r_state == ST_IDLE);
    assign o_cmd.start     = o_idle && i_req_valid;
    assign o_cmd.cfg_we    = o_idle && i_cfg_valid && !i_req_valid;
    assign o_cmd.rd_en     = (r_state == ST_SCAN) && !r_cnt[WADDR_W];
    assign o_cmd.rd_addr   = r_cnt[WADDR_W-1:0];
    assign o_cmd.proc_en   = (r_state == ST_SCAN) && (r_cnt != '0);
    assign o_cmd.proc_addr = WADDR_W'(r_cnt - 1'b1);
    assign o_cmd.finish    = (r_state == ST_FINISH) && i_sts.res_free;

`ifndef SYNTHESIS
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_en && o_cmd.proc_en |-> o_cmd.rd_addr != o_cmd.proc_addr)
        else $error("read and write address clash");
    a_scan_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> ##(NWORDS + 1) r_state == ST_FINISH)
        else $error("scan length wrong");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> o_idle)
        else $error("finish did not return to idle");
`endif

endmodule

>>> sv/tbs_datapath.sv
// Word store, per-word update logic, accumulators and result register.
// Depends on tbs_pkg.
`timescale 1ns / 1ps

module tbs_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  tbs_pkg::t_cmd             i_cmd,
    input  logic [3:0]                i_action,
    input  logic [tbs_pkg::IDX_W-1:0] i_index,
    input  logic [tbs_pkg::IDX_W-1:0] i_range_end,
    input  logic [tbs_pkg::CNT_W-1:0] i_cfg_data,
    input  logic                      i_res_ready,
    output tbs_pkg::t_sts             o_sts,
    output logic                      o_res_valid,
    output tbs_pkg::t_result          o_res
);
    import tbs_pkg::*;

    logic [WORD_BITS-1:0] r_mem [NWORDS];
    logic [NWORDS-1:0]    r_wvld;
    logic [WORD_BITS-1:0] r_rd_data;
    logic                 r_rd_vld;
    logic [CNT_W-1:0]     r_bits;

    logic [3:0]       r_action;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_end;
    logic [CNT_W-1:0] r_n;
    logic             r_idx_ok;

    logic [CNT_W-1:0] r_pop;
    logic [IDX_W-1:0] r_low;
    logic [IDX_W-1:0] r_high;
    logic             r_any;
    logic [IDX_W-1:0] r_fnd;
    logic             r_fvld;
    logic             r_bit;

    logic             r_res_vld;
    t_result          r_res;

    logic [CNT_W-1:0]     n_n;
    logic [IDX_W-1:0]     n_end;
    logic [WORD_BITS-1:0] old_w, new_w, act_m, inr_m, abv_m, blw_m, eq_m;
    logic [WORD_BITS-1:0] cand_nx, cand_pv;
    logic [IDX_W-1:0]     base;
    logic [CNT_W-1:0]     pos;

    // clamp active count and range end for the incoming request
    always_comb begin
        n_n = r_bits;
        if (r_bits == '0) n_n = CNT_W'(1);
        if (r_bits > CNT_W'(NBITS)) n_n = CNT_W'(NBITS);
        n_end = i_range_end;
        if (CNT_W'(i_range_end) > n_n - 1'b1) n_end = IDX_W'(n_n - 1'b1);
    end

    // build per-bit masks and the updated word
    always_comb begin
        base  = IDX_W'({i_cmd.proc_addr, WBIT_W'(0)});
        old_w = r_rd_vld ? r_rd_data : '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            pos      = CNT_W'(base) + CNT_W'(j);
            act_m[j] = pos < r_n;
            eq_m[j]  = pos[IDX_W-1:0] == r_idx;
            inr_m[j] = (pos[IDX_W-1:0] >= r_idx) && (pos[IDX_W-1:0] <= r_end);
            abv_m[j] = pos[IDX_W-1:0] > r_idx;
            blw_m[j] = pos[IDX_W-1:0] < r_idx;
        end
        case (r_action)
            ACT_SET:      new_w = r_idx_ok ? (old_w | eq_m) : old_w;
            ACT_CLEAR:    new_w = r_idx_ok ? (old_w & ~eq_m) : old_w;
            ACT_SET_RNG:  new_w = r_idx_ok ? (old_w | inr_m) : old_w;
            ACT_CLR_RNG:  new_w = r_idx_ok ? (old_w & ~inr_m) : old_w;
            ACT_KEEP_RNG: new_w = r_idx_ok ? (old_w & inr_m) : old_w;
            ACT_SET_ALL:  new_w = act_m;
            ACT_CLR_ALL:  new_w = '0;
            ACT_INVERT:   new_w = ~old_w;
            default:      new_w = old_w;
        endcase
        new_w   = new_w & act_m;
        cand_nx = (r_action == ACT_NEXT) ? (new_w & abv_m) : '0;
        cand_pv = ((r_action == ACT_PREV) && r_idx_ok) ? (new_w & blw_m) : '0;
    end

    // word store: registered read, write back of the processed word
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) r_rd_data <= r_mem[i_cmd.rd_addr];
        if (i_cmd.proc_en) r_mem[i_cmd.proc_addr] <= new_w;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvld   <= '0;
            r_rd_vld <= 1'b0;
            r_bits   <= CNT_W'(NBITS);
        end else begin
            if (i_cmd.rd_en) r_rd_vld <= r_wvld[i_cmd.rd_addr];
            if (i_cmd.proc_en) r_wvld[i_cmd.proc_addr] <= 1'b1;
            // a register write empties the store
            if (i_cmd.cfg_we) begin
                r_bits <= i_cfg_data;
                r_wvld <= '0;
            end
        end
    end

    // latch the request and accumulate over the words
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_action <= i_action;
            r_idx    <= i_index;
            r_end    <= n_end;
            r_n      <= n_n;
            r_idx_ok <= CNT_W'(i_index) < n_n;
            r_pop    <= '0;
            r_low    <= '0;
            r_high   <= '0;
            r_any    <= 1'b0;
            r_fnd    <= '0;
            r_fvld   <= 1'b0;
            r_bit    <= 1'b0;
        end else if (i_cmd.proc_en) begin
            r_pop <= r_pop + CNT_W'(pop_word(new_w));
            if (new_w != '0) begin
                if (!r_any) r_low <= base | IDX_W'(lowest_bit(new_w));
                r_high <= base | IDX_W'(highest_bit(new_w));
                r_any  <= 1'b1;
            end
            if (!r_fvld && cand_nx != '0) begin
                r_fnd  <= base | IDX_W'(lowest_bit(cand_nx));
                r_fvld <= 1'b1;
            end
            if (cand_pv != '0) begin
                r_fnd  <= base | IDX_W'(highest_bit(cand_pv));
                r_fvld <= 1'b1;
            end
            if (r_idx_ok && i_cmd.proc_addr == r_idx[IDX_W-1:WBIT_W]) begin
                r_bit <= new_w[r_idx[WBIT_W-1:0]];
            end
        end
    end

    // result register: load on finish, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else if (i_cmd.finish) begin
            r_res_vld <= 1'b1;
        end else if (i_res_ready) begin
            r_res_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_res.bit_value   <= r_bit;
            r_res.found_index <= r_fnd;
            r_res.found_valid <= r_fvld;
            r_res.set_count   <= r_pop;
            r_res.lowest_set  <= r_low;
            r_res.highest_set <= r_high;
            r_res.any_set     <= r_any;
            r_res.all_set     <= r_pop == r_n;
        end
    end

    assign o_sts.res_free = !r_res_vld || i_res_ready;
    assign o_res_valid    = r_res_vld;
    assign o_res          = r_res;

`ifndef SYNTHESIS
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_vld && !i_res_ready |=> r_res_vld && $stable(r_res))
        else $error("stalled result changed");
    a_any_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_vld |-> r_res.any_set == (r_res.set_count != '0))
        else $error("any_set disagrees with count");
    a_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_vld |-> r_res.lowest_set <= r_res.highest_set)
        else $error("lowest above highest");
`endif

endmodule

>>> sv/tracked_bitmap_set.sv
// Top level of the tracked bitmap set: sequencer plus datapath.
// Depends on tbs_pkg, tbs_ifs, tbs_ctrl and tbs_datapath.
//
// Each request walks the 32-word store once, reading one word and writing
// back the previous one per cycle; the result register is then loaded as
// soon as the result side is free. The sequencer passes through idle
// between scans, so a request is taken only once the previous scan is
// through, and the next request is taken while a result still waits. The
// store is empty after reset and after any write of bits_in_use, with no
// clearing pass. Configuration is taken only between requests.
`timescale 1ns / 1ps

module tracked_bitmap_set (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tbs_req_if.sink       i_req,
    tbs_cfg_if.sink       i_cfg,
    tbs_res_if.source     o_res
);
    import tbs_pkg::*;

    t_cmd    cmd;
    t_sts    sts;
    t_result res;
    logic    idle;

    tbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_cfg_valid (i_cfg.valid),
        .i_sts       (sts),
        .o_idle      (idle),
        .o_cmd       (cmd)
    );

    tbs_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_action    (i_req.action),
        .i_index     (i_req.index),
        .i_range_end (i_req.range_end),
        .i_cfg_data  (i_cfg.data),
        .i_res_ready (o_res.ready),
        .o_sts       (sts),
        .o_res_valid (o_res.valid),
        .o_res       (res)
    );

    // requests and configuration beats are taken only between scans
    assign i_req.ready = idle;
    assign i_cfg.ready = idle && !i_req.valid;

    assign o_res.bit_value   = res.bit_value;
    assign o_res.found_index = res.found_index;
    assign o_res.found_valid = res.found_valid;
    assign o_res.set_count   = res.set_count;
    assign o_res.lowest_set  = res.lowest_set;
    assign o_res.highest_set = res.highest_set;
    assign o_res.any_set     = res.any_set;
    assign o_res.all_set     = res.all_set;

endmodule

>>> test/tracked_bitmap_set_tb.sv
// Self-checking testbench for the tracked bitmap set: drives request and
// configuration beats, predicts every result and compares it as a whole.
// Depends on tbs_pkg, tbs_ifs and tracked_bitmap_set.
`timescale 1ns / 1ps

module tracked_bitmap_set_tb;
    import tbs_pkg::*;

    logic i_clk;
    logic i_rst_n;

    tbs_req_if req_ch ();
    tbs_res_if res_ch ();
    tbs_cfg_if cfg_ch ();

    tracked_bitmap_set dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .i_cfg   (cfg_ch.sink),
        .o_res   (res_ch.source)
    );

    // Shadow of the bitmap and its settings
    logic [NBITS-1:0] shadow_bits;
    int unsigned      active_bits;
    t_result          pending_results[$];

    int send_idle_pct;
    int recv_idle_pct;
    bit hold_off;
    int errors;
    int beats_sent;
    int beats_checked;
    int quiet_cycles;

    // Generate the clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Rebuild the count, marks, flags and tested bit from the shadow store
    function automatic t_result bitmap_status(input logic [IDX_W-1:0] idx);
        t_result r;
        bit seen;
        r = '0;
        seen = 1'b0;
        for (int i = 0; i < active_bits; i++) begin
            if (shadow_bits[i]) begin
                r.set_count = r.set_count + 1'b1;
                if (!seen) r.lowest_set = IDX_W'(i);
                r.highest_set = IDX_W'(i);
                seen = 1'b1;
            end
        end
        r.any_set = (r.set_count != 0);
        r.all_set = (r.set_count == active_bits);
        r.bit_value = (idx < active_bits) ? shadow_bits[idx] : 1'b0;
        return r;
    endfunction

    // Apply one request to the shadow store and return the expected status
    function automatic t_result apply_request(input logic [3:0] act,
                                              input logic [IDX_W-1:0] idx,
                                              input logic [IDX_W-1:0] rend);
        t_result r;
        int unsigned last;
        logic [IDX_W-1:0] fidx;
        logic fvalid;
        last = (rend > active_bits - 1) ? active_bits - 1 : rend;
        fidx = '0;
        fvalid = 1'b0;
        case (act)
            ACT_SET: begin
                if (idx < active_bits) shadow_bits[idx] = 1'b1;
            end
            ACT_CLEAR: begin
                if (idx < active_bits) shadow_bits[idx] = 1'b0;
            end
            ACT_SET_RNG, ACT_CLR_RNG: begin
                if (idx < active_bits)
                    for (int i = idx; i <= last; i++) shadow_bits[i] = (act == ACT_SET_RNG);
            end
            ACT_KEEP_RNG: begin
                if (idx < active_bits)
                    for (int i = 0; i < active_bits; i++)
                        if (i < idx || i > last) shadow_bits[i] = 1'b0;
            end
            ACT_SET_ALL: begin
                for (int i = 0; i < active_bits; i++) shadow_bits[i] = 1'b1;
            end
            ACT_CLR_ALL: begin
                for (int i = 0; i < active_bits; i++) shadow_bits[i] = 1'b0;
            end
            ACT_INVERT: begin
                for (int i = 0; i < active_bits; i++) shadow_bits[i] = ~shadow_bits[i];
            end
            ACT_NEXT: begin
                for (int i = idx + 1; i < active_bits; i++)
                    if (shadow_bits[i]) begin
                        fidx = IDX_W'(i);
                        fvalid = 1'b1;
                        break;
                    end
            end
            ACT_PREV: begin
                if (idx < active_bits)
                    for (int i = int'(idx) - 1; i >= 0; i--)
                        if (shadow_bits[i]) begin
                            fidx = IDX_W'(i);
                            fvalid = 1'b1;
                            break;
                        end
            end
            default: ;
        endcase
        r = bitmap_status(idx);
        r.found_index = fidx;
        r.found_valid = fvalid;
        return r;
    endfunction

    // Send one request beat, idling first at the current rate
    task automatic send_request(input logic [3:0] act, input logic [IDX_W-1:0] idx,
                                input logic [IDX_W-1:0] rend);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.action    <= act;
        req_ch.index     <= idx;
        req_ch.range_end <= rend;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        pending_results.push_back(apply_request(act, idx, rend));
        beats_sent++;
    endtask

    // Drop the request, wait until every result is back plus a settling gap
    task automatic drain;
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // Write bits_in_use while the block is idle
    task automatic write_width(input logic [CNT_W-1:0] value);
        int unsigned n;
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        n = value;
        if (n == 0) n = 1;
        if (n > NBITS) n = NBITS;
        active_bits = n;
        shadow_bits = '0;
        @(posedge i_clk);
    endtask

    // Index biased towards the active region and its edges
    function automatic logic [IDX_W-1:0] pick_index();
        case ($urandom_range(9))
            0: return IDX_W'($urandom);
            1: return IDX_W'(active_bits - 1);
            2: return '0;
            default: return IDX_W'($urandom_range(active_bits - 1));
        endcase
    endfunction

    task automatic random_requests(input int count);
        logic [3:0] act;
        for (int k = 0; k < count; k++) begin
            act = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 11))
                                            : 4'($urandom_range(ACT_PREV));
            send_request(act, pick_index(), pick_index());
        end
    endtask

    task automatic test_directed;
        write_width(CNT_W'(NBITS));
        send_request(ACT_TEST, '0, '0);
        send_request(ACT_NEXT, '0, '0);
        send_request(ACT_SET, '0, '0);
        send_request(ACT_SET, 10'd1023, '0);
        send_request(ACT_NEXT, '0, '0);
        send_request(ACT_PREV, 10'd1023, '0);
        send_request(ACT_PREV, '0, '0);
        send_request(ACT_SET_RNG, 10'd100, 10'd200);
        send_request(ACT_CLR_RNG, 10'd150, 10'd1023);
        send_request(ACT_SET_RNG, 10'd300, 10'd299);
        send_request(ACT_KEEP_RNG, 10'd120, 10'd140);
        send_request(ACT_KEEP_RNG, 10'd140, 10'd120);
        send_request(ACT_SET_ALL, '0, '0);
        send_request(ACT_CLEAR, 10'd512, '0);
        send_request(ACT_INVERT, 10'd512, '0);
        send_request(ACT_CLR_ALL, 10'd5, '0);
        send_request(4'd15, 10'd5, 10'd5);
        write_width(CNT_W'(40));
        send_request(ACT_SET_RNG, 10'd30, 10'd1023);
        send_request(ACT_SET, 10'd800, '0);
        send_request(ACT_PREV, 10'd600, '0);
        send_request(ACT_INVERT, 10'd39, '0);
        send_request(ACT_TEST, 10'h3FF, 10'h3FF);
        write_width('0);
        send_request(ACT_INVERT, '0, '0);
        write_width(11'h7FF);
        send_request(ACT_SET_ALL, 10'd1, '0);
    endtask

    task automatic test_random_widths;
        int widths[6] = '{1, 33, 1024, 200, 7, 1024};
        foreach (widths[w]) begin
            write_width(CNT_W'(widths[w]));
            random_requests(250);
        end
    endtask

    // Stall the result side for a long stretch so the input backs up
    task automatic test_backpressure;
        drain();
        hold_off = 1'b1;
        fork
            random_requests(20);
            begin
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
        join
    endtask

    // Result side: stall at random and check each beat
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                got = '{res_ch.bit_value, res_ch.found_index, res_ch.found_valid,
                        res_ch.set_count, res_ch.lowest_set, res_ch.highest_set,
                        res_ch.any_set, res_ch.all_set};
                beats_checked++;
                if (pending_results.size() == 0) begin
                    $display("%0t: result with none expected, actual %p", $time, got);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
                        errors++;
                    end
                end
            end
            res_ch.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on accepted beats
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        beats_sent = 0;
        hold_off = 1'b0;
        active_bits = NBITS;
        shadow_bits = '0;
        send_idle_pct = 37;
        recv_idle_pct = 52;
        req_ch.valid <= 1'b0;
        req_ch.action <= '0;
        req_ch.index <= '0;
        req_ch.range_end <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data <= '0;
        i_rst_n <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_widths();
        send_idle_pct = 52;
        recv_idle_pct = 37;
        test_backpressure();
        random_requests(200);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_width(CNT_W'(500));
        random_requests(110);
        drain();

        $display("Covered %0d requests and %0d results over several bitmap widths,",
                 beats_sent, beats_checked);
        $display("with random stalls on both sides and one long result stall.");
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> files.f
sv/tbs_pkg.sv
sv/tbs_ifs.sv
sv/tbs_ctrl.sv
sv/tbs_datapath.sv
sv/tracked_bitmap_set.sv
test/tracked_bitmap_set_tb.sv
